>>> rtl/tlg_pkg.sv
// Shared types and constants for the tremolo gain unit.
// Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps

package tlg_pkg;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int DEPTH_W  = 14;
  localparam int PERIOD_W = 16;
  localparam int STEP_W   = 31;
  localparam int GAIN_W   = 32;
  localparam int TICK_W   = 16;
  localparam int G15_W    = 15;
  localparam int ROM_W    = 16;
  localparam int MUL_W    = 33;
  localparam int ACC_W    = 49;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = 3;

  // Oscillator constants: gain values Q1.31, smoothing weights Q0.16
  localparam logic [GAIN_W-1:0] HALF_GAIN  = 32'h4000_0000;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 32'h7FFF_FFFF;
  localparam logic [16:0]       SMOOTH_K   = 17'd655;
  localparam logic [16:0]       SMOOTH_KEEP = 17'd64881;
  localparam logic [15:0]       ROUND_HALF = 16'h8000;
  localparam logic [G15_W-1:0]  G15_MAX    = 15'h7FFF;
  localparam longint unsigned   HALF_PI_Q30 = 64'd1686629713;

  // Waveform codes
  localparam logic [MODE_W-1:0] MODE_SINE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SQUARE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRIANGLE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RAMP     = 2'd3;

  // Register indexes (byte address / 4)
  localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEP       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = 3'd4;

  // Register reset values
  localparam logic [MODE_W-1:0]   MODE_RST       = MODE_SINE;
  localparam logic [DEPTH_W-1:0]  DEPTH_RST      = 14'd9830;
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 16'd24000;
  localparam logic [STEP_W-1:0]   STEP_RST       = 31'd53687;
  localparam logic [STEP_W-1:0]   PHASE_STEP_RST = 31'd178957;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [DEPTH_W-1:0]  depth;
    logic [PERIOD_W-1:0] period;
    logic [STEP_W-1:0]   step;
    logic [STEP_W-1:0]   phase_step;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PHASE,
    OP_INDEX,
    OP_SINE_GAIN,
    OP_SQUARE,
    OP_RAMP,
    OP_TRI,
    OP_SMOOTH_A,
    OP_SMOOTH_B,
    OP_SCALE
  } op_t;

  typedef struct packed {
    logic capture;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHASE,
    ST_INDEX,
    ST_ROM,
    ST_SINE_GAIN,
    ST_TARGET,
    ST_SMOOTH_A,
    ST_SMOOTH_B,
    ST_TRI,
    ST_SCALE
  } state_t;

endpackage

>>> rtl/tremolo_lfo_gain_unit.sv
// Top level of the tremolo gain unit: configuration registers, sequencer
// and datapath. Depends on tlg_pkg, tlg_regs, tlg_ctrl and tlg_dpath.
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid / in_ready with one signed sample per request.
//   Output channel: out_valid / out_ready with the scaled sample and the
//   Q0.15 gain applied to it. Each request gives exactly one result.
//   Configuration: APB-style port, register i at byte address 4*i (mode,
//   depth, period, step, phase_step); write only while the unit is idle.
// Timing
//   The request is taken in the idle cycle, then walks through a fixed
//   step sequence that shares one 33x33 signed multiplier; the next
//   request is taken once the previous one has passed its scale step:
//     sine           phase, index, table read, sine gain, scale
//     square, ramp   target, smooth A, smooth B, scale
//     triangle       triangle step, scale
//   The sine path spends extra cycles on the phase and index multiplies
//   and on the registered table read.
// Reset and stalls
//   Reset (rst, synchronous) restores the register defaults, sets the gain
//   to 0.5 and clears target, tick counter and direction. A new request is
//   taken while the previous result waits in the output register; the unit
//   holds in its final step until the receiver takes that result.
module tremolo_lfo_gain_unit import tlg_pkg::*; #(
  parameter int SINE_ENTRIES = 256,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [PDATA_W-1:0]            pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic [G15_W-1:0]              gain_now
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  tlg_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  // Sequencer: one request at a time, picks the step list from the mode
  tlg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode    (cfg.mode),
    .status  (status),
    .cmd     (cmd)
  );

  // Datapath: oscillator state, shared multiplier, sine table, output slot
  tlg_dpath #(
    .SINE_ENTRIES(SINE_ENTRIES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out),
    .gain_now  (gain_now)
  );

  // A taken request keeps the sequencer busy in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a request");

  // Never overwrite a result the receiver has not taken
  a_scale_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_SCALE |-> !status.out_busy)
    else $error("result written over a pending result");

  // A new result only appears after the scaling step
  a_result_from_scale: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.op == OP_SCALE))
    else $error("output valid rose without a scaling step");

endmodule

>>> rtl/tlg_regs.sv
// APB-style configuration registers of the tremolo gain unit.
// Depends on tlg_pkg for the register map and the cfg_t bundle.
`timescale 1ns / 1ps

module tlg_regs import tlg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= MODE_RST;
      cfg.depth      <= DEPTH_RST;
      cfg.period     <= PERIOD_RST;
      cfg.step       <= STEP_RST;
      cfg.phase_step <= PHASE_STEP_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:       cfg.mode       <= pwdata[MODE_W-1:0];
        REG_DEPTH:      cfg.depth      <= pwdata[DEPTH_W-1:0];
        REG_PERIOD:     cfg.period     <= pwdata[PERIOD_W-1:0];
        REG_STEP:       cfg.step       <= pwdata[STEP_W-1:0];
        REG_PHASE_STEP: cfg.phase_step <= pwdata[STEP_W-1:0];
        default: ;  // drop writes past the map
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:       prdata = PDATA_W'(cfg.mode);
      REG_DEPTH:      prdata = PDATA_W'(cfg.depth);
      REG_PERIOD:     prdata = PDATA_W'(cfg.period);
      REG_STEP:       prdata = PDATA_W'(cfg.step);
      REG_PHASE_STEP: prdata = PDATA_W'(cfg.phase_step);
      default:        prdata = '0;
    endcase
  end

endmodule

>>> rtl/tlg_sine_rom.sv
// Sine table for the oscillator, built at elaboration by a fixed integer
// Taylor series; registered read. Depends on tlg_pkg for constants.
`timescale 1ns / 1ps

module tlg_sine_rom import tlg_pkg::*; #(
  parameter int SINE_ENTRIES = 256
) (
  input  logic                            clk,
  input  logic [$clog2(SINE_ENTRIES)-1:0] addr,
  output logic signed [ROM_W-1:0]         data
);

  localparam longint unsigned N = SINE_ENTRIES;

  logic signed [ROM_W-1:0] rom_tab [SINE_ENTRIES];

  for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_tab
    localparam longint unsigned Kx4 = 64'(4 * k);
    localparam longint unsigned Q   = Kx4 / N;
    localparam longint unsigned R0  = Kx4 - Q * N;
    localparam longint unsigned R   = (Q[0]) ? N - R0 : R0;
    localparam longint unsigned X   = (HALF_PI_Q30 * R) / N;
    localparam longint unsigned X2  = (X * X) >> 30;
    localparam longint unsigned T3  = ((X * X2) >> 30) / 6;
    localparam longint unsigned T5  = ((T3 * X2) >> 30) / 20;
    localparam longint unsigned T7  = ((T5 * X2) >> 30) / 42;
    localparam longint unsigned T9  = ((T7 * X2) >> 30) / 72;
    localparam longint S  = longint'(X) - longint'(T3) + longint'(T5)
                          - longint'(T7) + longint'(T9);
    localparam longint unsigned S0 = (S < 0) ? 64'd0 : longint'(S);
    localparam longint unsigned V0 = (S0 * 64'd32767 + 64'd536870912) >> 30;
    localparam longint unsigned V  = (V0 > 64'd32767) ? 64'd32767 : V0;
    localparam logic [ROM_W-1:0] Entry = (Q >= 2) ? ROM_W'(64'd0 - V) : ROM_W'(V);

    assign rom_tab[k] = Entry;
  end

  always_ff @(posedge clk) begin
    data <= rom_tab[addr];
  end

endmodule

>>> rtl/tlg_ctrl.sv
// Sequencer of the tremolo gain unit: walks each request through the steps
// of its waveform and drives the datapath. Depends on tlg_pkg.
`timescale 1ns / 1ps

module tlg_ctrl import tlg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] mode,
  input  status_t           status,
  output cmd_t              cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.op      = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (mode)
            MODE_SINE:     state_next = ST_PHASE;
            MODE_TRIANGLE: state_next = ST_TRI;
            MODE_SQUARE,
            MODE_RAMP:     state_next = ST_TARGET;
            default:       state_next = ST_PHASE;
          endcase
        end
      end
      ST_PHASE: begin
        cmd.op     = OP_PHASE;
        state_next = ST_INDEX;
      end
      ST_INDEX: begin
        cmd.op     = OP_INDEX;
        state_next = ST_ROM;
      end
      ST_ROM: begin
        // wait out the table read
        state_next = ST_SINE_GAIN;
      end
      ST_SINE_GAIN: begin
        cmd.op     = OP_SINE_GAIN;
        state_next = ST_SCALE;
      end
      ST_TARGET: begin
        cmd.op     = (mode == MODE_RAMP) ? OP_RAMP : OP_SQUARE;
        state_next = ST_SMOOTH_A;
      end
      ST_SMOOTH_A: begin
        cmd.op     = OP_SMOOTH_A;
        state_next = ST_SMOOTH_B;
      end
      ST_SMOOTH_B: begin
        cmd.op     = OP_SMOOTH_B;
        state_next = ST_SCALE;
      end
      ST_TRI: begin
        cmd.op     = OP_TRI;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        // hold until the output slot frees up
        if (!status.out_busy) begin
          cmd.op     = OP_SCALE;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/tlg_dpath.sv
// Datapath of the tremolo gain unit: oscillator state, one shared signed
// multiplier, the sine table and the output register. Depends on tlg_pkg.
`timescale 1ns / 1ps

module tlg_dpath import tlg_pkg::*; #(
  parameter int SINE_ENTRIES = 256,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  cmd_t                          cmd,
  output status_t                       status,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic [G15_W-1:0]              gain_now
);

  localparam int IDX_W = $clog2(SINE_ENTRIES);

  // Oscillator state
  logic [GAIN_W-1:0] gain_acc;
  logic [GAIN_W-1:0] target_gain;
  logic [TICK_W-1:0] tick_count;
  logic              falling;

  // Per-request scratch
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [GAIN_W-1:0]             phase_r;
  logic [IDX_W-1:0]              idx_r;
  logic [ACC_W-1:0]              acc_r;
  logic signed [ROM_W-1:0]       rom_data;

  logic [GAIN_W-1:0]       depth_q31, lo, hi;
  logic [G15_W-1:0]        g15;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;
  logic [GAIN_W-1:0]       sine_gain;
  logic [ACC_W:0]          smooth_sum;
  logic signed [GAIN_W+1:0] tri_base, tri_delta, tri_sum;
  logic [GAIN_W-1:0]       tri_gain;
  logic [GAIN_W:0]         ramp_sum;
  logic                    sine_clr, square_clr;

  tlg_sine_rom #(
    .SINE_ENTRIES(SINE_ENTRIES)
  ) u_rom (
    .clk (clk),
    .addr(idx_r),
    .data(rom_data)
  );

  assign depth_q31 = {2'b00, cfg.depth, 16'h0000};
  assign lo        = HALF_GAIN - depth_q31;
  assign hi        = HALF_GAIN + depth_q31;
  assign g15       = gain_acc[GAIN_W-1] ? G15_MAX : gain_acc[GAIN_W-2:16];

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_PHASE: begin
        mul_a = MUL_W'(tick_count);
        mul_b = MUL_W'(cfg.phase_step);
      end
      OP_INDEX: begin
        mul_a = MUL_W'(phase_r);
        mul_b = MUL_W'(SINE_ENTRIES);
      end
      OP_SINE_GAIN: begin
        mul_a = MUL_W'(cfg.depth);
        mul_b = MUL_W'(rom_data);
      end
      OP_SMOOTH_A: begin
        mul_a = MUL_W'(gain_acc);
        mul_b = MUL_W'(SMOOTH_KEEP);
      end
      OP_SMOOTH_B: begin
        mul_a = MUL_W'(target_gain);
        mul_b = MUL_W'(SMOOTH_K);
      end
      OP_SCALE: begin
        mul_a = MUL_W'(sample_r);
        mul_b = MUL_W'(g15);
      end
      OP_NONE, OP_SQUARE, OP_RAMP, OP_TRI: ;
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // Gain = 0.5 + 2*depth*entry; stays in range for any 14-bit depth
  assign sine_gain  = HALF_GAIN + {prod[GAIN_W-2:0], 1'b0};
  assign smooth_sum = {1'b0, acc_r} + {1'b0, prod[ACC_W-1:0]} + (ACC_W+1)'(ROUND_HALF);

  assign tri_base  = {2'b00, gain_acc};
  assign tri_delta = {2'b00, cfg.step, 1'b0};
  assign tri_sum   = falling ? tri_base - tri_delta : tri_base + tri_delta;

  always_comb begin
    priority if (tri_sum[GAIN_W+1]) begin
      tri_gain = '0;
    end else if (tri_sum[GAIN_W:GAIN_W-1] != 2'b00) begin
      tri_gain = GAIN_MAX;
    end else begin
      tri_gain = tri_sum[GAIN_W-1:0];
    end
  end

  assign ramp_sum   = {1'b0, target_gain} + (GAIN_W+1)'(cfg.step);
  assign sine_clr   = tick_count >= cfg.period;
  assign square_clr = tick_count >= {1'b0, cfg.period[PERIOD_W-1:1]};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= sample_in;
    end
    if (cmd.op == OP_PHASE) begin
      phase_r <= prod[GAIN_W-1:0];
    end
    if (cmd.op == OP_INDEX) begin
      idx_r <= prod[GAIN_W+IDX_W-1:GAIN_W];
    end
    if (cmd.op == OP_SMOOTH_A) begin
      acc_r <= prod[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_acc    <= HALF_GAIN;
      target_gain <= '0;
      tick_count  <= '0;
      falling     <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_SINE_GAIN: begin
          gain_acc   <= sine_gain;
          tick_count <= sine_clr ? TICK_W'(1) : tick_count + TICK_W'(1);
        end
        OP_SQUARE: begin
          if (square_clr) begin
            target_gain <= (target_gain == lo) ? hi : lo;
            tick_count  <= TICK_W'(1);
          end else begin
            tick_count  <= tick_count + TICK_W'(1);
          end
        end
        OP_RAMP: begin
          if (ramp_sum >= {1'b0, hi}) begin
            target_gain <= lo;
            tick_count  <= TICK_W'(1);
          end else begin
            target_gain <= ramp_sum[GAIN_W-1:0];
            tick_count  <= tick_count + TICK_W'(1);
          end
        end
        OP_TRI: begin
          gain_acc <= tri_gain;
          if (tri_gain >= hi || tri_gain <= lo) begin
            falling    <= ~falling;
            tick_count <= TICK_W'(1);
          end else begin
            tick_count <= tick_count + TICK_W'(1);
          end
        end
        OP_SMOOTH_B: begin
          gain_acc <= smooth_sum[ACC_W-2:16];
        end
        OP_NONE, OP_PHASE, OP_INDEX, OP_SMOOTH_A, OP_SCALE: ;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_SCALE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SCALE) begin
      sample_out <= prod[SAMPLE_BITS+14:15];
      gain_now   <= g15;
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule
